// ===== rtl/core/tmc_pkg.sv =====
// ----------------------------------------------------------------------------
// tmc_pkg
// Shared types, constants and helpers of the transform matrix composer.
// ----------------------------------------------------------------------------
package tmc_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // Operation codes carried in the mode field
  localparam logic [1:0] MODE_TRANSLATE = 2'd0;
  localparam logic [1:0] MODE_SCALE     = 2'd1;
  localparam logic [1:0] MODE_ROTATE    = 2'd2;

  // Axis operand selectors
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // CORDIC setup: Q30 datapath, angle unit 2*pi/2^24
  localparam int CORDIC_ITERS = 20;
  localparam int CW = 35;
  localparam int ZW = 24;
  localparam logic signed [CW-1:0] CORDIC_K_Q30 = 35'sd652032874;

  // One request as held in the queue
  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] p0;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
    logic [15:0]        angle;
  } item_t;

  // Recipe for one rotation entry: a*b*t then plus c or plus/minus d*s
  typedef struct packed {
    logic [1:0] sa;
    logic [1:0] sb;
    logic [1:0] sd;
    logic       diag;
    logic       sub;
  } rot_info_t;

  // Handshake between engine and CORDIC unit
  typedef struct packed {
    logic start;
    logic done;
  } cs_ctrl_t;

  // Arctangent table in CORDIC angle units
  function automatic logic signed [ZW-1:0] atan_val(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:  v = 24'sd2097152;
      5'd1:  v = 24'sd1238021;
      5'd2:  v = 24'sd654136;
      5'd3:  v = 24'sd332050;
      5'd4:  v = 24'sd166669;
      5'd5:  v = 24'sd83416;
      5'd6:  v = 24'sd41718;
      5'd7:  v = 24'sd20860;
      5'd8:  v = 24'sd10430;
      5'd9:  v = 24'sd5215;
      5'd10: v = 24'sd2608;
      5'd11: v = 24'sd1304;
      5'd12: v = 24'sd652;
      5'd13: v = 24'sd326;
      5'd14: v = 24'sd163;
      5'd15: v = 24'sd81;
      5'd16: v = 24'sd41;
      5'd17: v = 24'sd20;
      5'd18: v = 24'sd10;
      5'd19: v = 24'sd5;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Rotation entry recipes, index = 3*row + col
  function automatic rot_info_t rot_info(input logic [3:0] e);
    rot_info_t r;
    case (e)
      4'd0: r = '{AXIS_X, AXIS_X, AXIS_X, 1'b1, 1'b0};
      4'd1: r = '{AXIS_X, AXIS_Y, AXIS_Z, 1'b0, 1'b1};
      4'd2: r = '{AXIS_X, AXIS_Z, AXIS_Y, 1'b0, 1'b0};
      4'd3: r = '{AXIS_X, AXIS_Y, AXIS_Z, 1'b0, 1'b0};
      4'd4: r = '{AXIS_Y, AXIS_Y, AXIS_Y, 1'b1, 1'b0};
      4'd5: r = '{AXIS_Y, AXIS_Z, AXIS_X, 1'b0, 1'b1};
      4'd6: r = '{AXIS_X, AXIS_Z, AXIS_Y, 1'b0, 1'b1};
      4'd7: r = '{AXIS_Y, AXIS_Z, AXIS_X, 1'b0, 1'b0};
      4'd8: r = '{AXIS_Z, AXIS_Z, AXIS_Z, 1'b1, 1'b0};
      default: r = '{AXIS_X, AXIS_X, AXIS_X, 1'b1, 1'b0};
    endcase
    return r;
  endfunction

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -36'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/transform_matrix_composer.sv =====
// ----------------------------------------------------------------------------
// transform_matrix_composer
// 4x4 Q-format transform matrix, updated by translate, scale or axis-angle
// rotate requests; all 16 entries are streamed out after every request.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | mode, p0, p1, p2, angle
//  out_    | output    | out_valid/out_stall| row, col, value, last
//
// Work per request runs on the single shared multiplier (one product
// issued per cycle in the matrix product), plus 20 CORDIC iterations for
// a rotate, and ends with streaming the 16 entries out.
// Reset: synchronous, matrix returns to identity at once.
// Stalls: a two-deep request queue decouples input from the engine; the
// output register holds an entry while out_stall is high.
module transform_matrix_composer
  import tmc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_mode,
  input  logic signed [31:0] in_p0,
  input  logic signed [31:0] in_p1,
  input  logic signed [31:0] in_p2,
  input  logic [15:0]        in_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_row,
  output logic [1:0]         out_col,
  output logic signed [31:0] out_value,
  output logic               out_last
);

  item_t              in_item;
  item_t              q_item;
  logic               q_valid;
  logic               q_pop;
  cs_ctrl_t           cs;
  logic               cs_done;
  logic signed [31:0] cs_cos, cs_sin;
  logic [15:0]        q_item_angle_hold;
  logic [15:0]        angle_r;

  assign in_item = '{mode: in_mode, p0: in_p0, p1: in_p1, p2: in_p2, angle: in_angle};

  // Front end request queue
  tmc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (in_valid),
    .item_i  (in_item),
    .full_o  (in_stall),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  // Sine/cosine unit
  tmc_cordic #(.FRAC_BITS(FRAC_BITS)) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (cs.start),
    .angle_i (q_item_angle_hold),
    .done_o  (cs_done),
    .cos_o   (cs_cos),
    .sin_o   (cs_sin)
  );

  // Angle of the request in flight, captured at pop
  always_ff @(posedge clk) begin
    if (q_pop) begin
      angle_r <= q_item.angle;
    end
  end
  assign q_item_angle_hold = angle_r;

  // Back end engine
  tmc_engine #(.FRAC_BITS(FRAC_BITS)) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .cs_o      (cs),
    .cs_done_i (cs_done),
    .cs_cos_i  (cs_cos),
    .cs_sin_i  (cs_sin),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_value (out_value),
    .out_last  (out_last)
  );

`ifndef SYNTHESIS
  // Last flag only on the final entry of a run
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_row == 2'd3 && out_col == 2'd3))
    else $error("last flag on wrong entry");

  // A run streams without gaps once its first entry is taken
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last) |=> out_valid)
    else $error("gap inside an output run");

  // Entries advance in row-major order
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last) |=>
      ({out_row, out_col} == $past({out_row, out_col}) + 4'd1))
    else $error("output entry order broken");
`endif

endmodule

// ===== rtl/core/tmc_queue.sv =====
// ----------------------------------------------------------------------------
// tmc_queue
// Front end: accepts requests and buffers them for the engine.
// ----------------------------------------------------------------------------
module tmc_queue
  import tmc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  item_t      mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign full_o  = (cnt_r == 2'd2);
  assign valid_o = (cnt_r != 2'd0);
  assign item_o  = mem_r[rd_ptr_r];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        mem_r[wr_ptr_r] <= item_i;
        wr_ptr_r        <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== rtl/core/tmc_cordic.sv =====
// ----------------------------------------------------------------------------
// tmc_cordic
// Iterative sine/cosine unit, one CORDIC micro-rotation per cycle.
// ----------------------------------------------------------------------------
module tmc_cordic
  import tmc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start_i,
  input  logic [15:0]        angle_i,
  output logic               done_o,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);

  localparam int SH = 30 - FRAC_BITS;
  localparam logic signed [CW-1:0] HALF = CW'(1) <<< (29 - FRAC_BITS);
  localparam logic [4:0] LAST_IT = 5'(CORDIC_ITERS - 1);

  logic signed [CW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;
  logic [4:0]           it_r;
  logic [1:0]           q_r;
  logic                 busy_r;
  logic                 done_r;

  logic [16:0]          asum;
  logic [1:0]           q_in;
  logic signed [15:0]   res_in;
  logic signed [CW-1:0] dx, dy;
  logic signed [CW-1:0] cv, sv, cr, sr;

  // Quarter-turn split of the angle
  assign asum   = {1'b0, angle_i} + 17'h2000;
  assign q_in   = asum[15:14];
  assign res_in = $signed(angle_i - {q_in, 14'd0});

  assign dx = y_r >>> it_r;
  assign dy = x_r >>> it_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      done_r <= busy_r && !start_i && (it_r == LAST_IT);
      if (start_i) begin
        x_r    <= CORDIC_K_Q30;
        y_r    <= '0;
        z_r    <= {res_in, 8'd0};
        q_r    <= q_in;
        it_r   <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (!z_r[ZW-1]) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - atan_val(it_r);
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + atan_val(it_r);
        end
        if (it_r == LAST_IT) begin
          busy_r <= 1'b0;
        end
        it_r <= it_r + 5'd1;
      end
    end
  end

  // Quadrant fix-up and rounding to the output format
  always_comb begin
    case (q_r)
      2'd0:    begin cv = x_r;  sv = y_r;  end
      2'd1:    begin cv = -y_r; sv = x_r;  end
      2'd2:    begin cv = -x_r; sv = -y_r; end
      default: begin cv = y_r;  sv = -x_r; end
    endcase
    cr = (cv + HALF) >>> SH;
    sr = (sv + HALF) >>> SH;
  end

  assign cos_o  = sat32(36'(cr));
  assign sin_o  = sat32(36'(sr));
  assign done_o = done_r;

endmodule

// ===== rtl/core/tmc_engine.sv =====
// ----------------------------------------------------------------------------
// tmc_engine
// Back end: holds the matrix, runs scale and rotate on one shared multiplier
// and streams the 16 entries out.
// ----------------------------------------------------------------------------
module tmc_engine
  import tmc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid_i,
  input  item_t              q_item_i,
  output logic               q_pop_o,
  output cs_ctrl_t           cs_o,
  input  logic               cs_done_i,
  input  logic signed [31:0] cs_cos_i,
  input  logic signed [31:0] cs_sin_i,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_row,
  output logic [1:0]         out_col,
  output logic signed [31:0] out_value,
  output logic               out_last
);

  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [64:0] RND = 65'sd1 <<< (FRAC_BITS - 1);

  typedef enum logic [4:0] {
    S_IDLE, S_TR, S_SC_I, S_SC_M, S_SC_W, S_CS_START, S_CS_WAIT, S_T,
    S_RU_I, S_RU_M, S_RV_I, S_RV_M, S_RW_I, S_RW_M, S_RFIN, S_MM, S_EMIT
  } state_t;

  state_t             state_r;
  logic signed [31:0] m_r [16];
  item_t              item_r;
  logic signed [31:0] c_r, s_r, t_r, v_r;
  logic signed [31:0] rot_r [9];
  logic signed [31:0] res_r [3];
  logic [6:0]         cnt_r;
  logic [3:0]         e_r;
  logic signed [31:0] ma_r, mb_r;
  logic signed [63:0] prod_r;
  logic signed [34:0] acc_r;
  logic               v1_r, v2_r;
  logic [5:0]         tag1_r, tag2_r;
  logic               out_valid_r, out_last_r;
  logic [1:0]         out_row_r, out_col_r;
  logic signed [31:0] out_value_r;

  logic signed [64:0] pr_rnd;
  logic signed [64:0] pr_sh;
  logic signed [31:0] fm;
  rot_info_t          ri;
  logic signed [31:0] tr_sum;
  logic signed [34:0] mm_sum;
  logic signed [31:0] mm_res;
  logic [1:0]         mi, mj, mk;
  logic [3:0]         rix;
  logic signed [31:0] rot_val;

  // Operand select for p0/p1/p2
  function automatic logic signed [31:0] pick(input item_t it, input logic [1:0] sel);
    logic signed [31:0] r;
    case (sel)
      AXIS_X:  r = it.p0;
      AXIS_Y:  r = it.p1;
      default: r = it.p2;
    endcase
    return r;
  endfunction

  // Rounded, saturated product of last cycle's operands
  always_comb begin
    pr_rnd = 65'(prod_r) + RND;
    pr_sh  = pr_rnd >>> FRAC_BITS;
    if (pr_sh > 65'sd2147483647) begin
      fm = 32'sh7fffffff;
    end else if (pr_sh < -65'sd2147483648) begin
      fm = 32'sh80000000;
    end else begin
      fm = pr_sh[31:0];
    end
  end

  assign ri     = rot_info(e_r);
  assign tr_sum = sat32(36'(m_r[{cnt_r[1:0], 2'b11}]) + 36'(pick(item_r, cnt_r[1:0])));

  // Matrix-multiply issue indices and rotation entry lookup
  assign mi  = cnt_r[5:4];
  assign mj  = cnt_r[3:2];
  assign mk  = cnt_r[1:0];
  assign rix = {1'b0, mk, 1'b0} + {2'b00, mk} + {2'b00, mj};
  always_comb begin
    if (mk == 2'd3 && mj == 2'd3) begin
      rot_val = ONE;
    end else if (mk == 2'd3 || mj == 2'd3) begin
      rot_val = '0;
    end else begin
      rot_val = rot_r[rix];
    end
  end

  // Accumulate stage of the multiply pipeline
  assign mm_sum = ((tag2_r[1:0] == 2'd0) ? 35'sd0 : acc_r) + 35'(fm);
  assign mm_res = sat32(36'(mm_sum));

  assign q_pop_o  = (state_r == S_IDLE) && q_valid_i;
  assign cs_o     = '{start: (state_r == S_CS_START), done: cs_done_i};

  // Shared multiplier, registered
  always_ff @(posedge clk) begin
    prod_r <= ma_r * mb_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      cnt_r       <= '0;
      e_r         <= '0;
      for (int n = 0; n < 16; n++) begin
        m_r[n] <= (n % 5 == 0) ? ONE : 32'sd0;
      end
    end else begin
      // Output register: load in the emit state, hold while stalled
      out_valid_r <= ((state_r == S_EMIT) && (!out_valid_r || !out_stall)) ||
                     (out_valid_r && out_stall);
      v1_r   <= (state_r == S_MM) && !cnt_r[6];
      v2_r   <= v1_r;
      tag2_r <= tag1_r;

      case (state_r)
        S_IDLE: begin
          if (q_valid_i) begin
            item_r <= q_item_i;
            cnt_r  <= '0;
            case (q_item_i.mode)
              MODE_TRANSLATE: state_r <= S_TR;
              MODE_SCALE:     state_r <= S_SC_I;
              MODE_ROTATE:    state_r <= S_CS_START;
              default:        state_r <= S_EMIT;
            endcase
          end
        end

        // Translate: one saturated add per cycle
        S_TR: begin
          m_r[{cnt_r[1:0], 2'b11}] <= tr_sum;
          if (cnt_r[1:0] == 2'd2) begin
            cnt_r   <= '0;
            state_r <= S_EMIT;
          end else begin
            cnt_r <= cnt_r + 7'd1;
          end
        end

        // Scale: diagonal entry times factor
        S_SC_I: begin
          ma_r    <= m_r[{cnt_r[1:0], cnt_r[1:0]}];
          mb_r    <= pick(item_r, cnt_r[1:0]);
          state_r <= S_SC_M;
        end
        S_SC_M: state_r <= S_SC_W;
        S_SC_W: begin
          m_r[{cnt_r[1:0], cnt_r[1:0]}] <= fm;
          if (cnt_r[1:0] == 2'd2) begin
            cnt_r   <= '0;
            state_r <= S_EMIT;
          end else begin
            cnt_r   <= cnt_r + 7'd1;
            state_r <= S_SC_I;
          end
        end

        // Rotate: sine and cosine first
        S_CS_START: state_r <= S_CS_WAIT;
        S_CS_WAIT: begin
          if (cs_done_i) begin
            c_r     <= cs_cos_i;
            s_r     <= cs_sin_i;
            state_r <= S_T;
          end
        end
        S_T: begin
          t_r     <= sat32(36'(ONE) - 36'(c_r));
          e_r     <= '0;
          state_r <= S_RU_I;
        end

        // Rotation entries, one recipe at a time
        S_RU_I: begin
          ma_r    <= pick(item_r, ri.sa);
          mb_r    <= pick(item_r, ri.sb);
          state_r <= S_RU_M;
        end
        S_RU_M: state_r <= S_RV_I;
        S_RV_I: begin
          ma_r    <= fm;
          mb_r    <= t_r;
          state_r <= S_RV_M;
        end
        S_RV_M: state_r <= S_RW_I;
        S_RW_I: begin
          v_r <= fm;
          if (ri.diag) begin
            rot_r[e_r] <= sat32(36'(fm) + 36'(c_r));
            if (e_r == 4'd8) begin
              cnt_r   <= '0;
              state_r <= S_MM;
            end else begin
              e_r     <= e_r + 4'd1;
              state_r <= S_RU_I;
            end
          end else begin
            ma_r    <= pick(item_r, ri.sd);
            mb_r    <= s_r;
            state_r <= S_RW_M;
          end
        end
        S_RW_M: state_r <= S_RFIN;
        S_RFIN: begin
          if (ri.sub) begin
            rot_r[e_r] <= sat32(36'(v_r) - 36'(fm));
          end else begin
            rot_r[e_r] <= sat32(36'(v_r) + 36'(fm));
          end
          if (e_r == 4'd8) begin
            cnt_r   <= '0;
            state_r <= S_MM;
          end else begin
            e_r     <= e_r + 4'd1;
            state_r <= S_RU_I;
          end
        end

        // M := M * R, one product issued per cycle, row written back whole
        S_MM: begin
          if (!cnt_r[6]) begin
            ma_r   <= m_r[{mi, mk}];
            mb_r   <= rot_val;
            tag1_r <= cnt_r[5:0];
            cnt_r  <= cnt_r + 7'd1;
          end
          if (v2_r) begin
            acc_r <= mm_sum;
            if (tag2_r[1:0] == 2'd3) begin
              if (tag2_r[3:2] == 2'd3) begin
                m_r[{tag2_r[5:4], 2'd0}] <= res_r[0];
                m_r[{tag2_r[5:4], 2'd1}] <= res_r[1];
                m_r[{tag2_r[5:4], 2'd2}] <= res_r[2];
                m_r[{tag2_r[5:4], 2'd3}] <= mm_res;
                if (tag2_r[5:4] == 2'd3) begin
                  cnt_r   <= '0;
                  state_r <= S_EMIT;
                end
              end else begin
                res_r[tag2_r[3:2]] <= mm_res;
              end
            end
          end
        end

        // Stream the 16 entries in row-major order
        S_EMIT: begin
          if (!out_valid_r || !out_stall) begin
            out_value_r <= m_r[cnt_r[3:0]];
            out_row_r   <= cnt_r[3:2];
            out_col_r   <= cnt_r[1:0];
            out_last_r  <= (cnt_r[3:0] == 4'd15);
            if (cnt_r[3:0] == 4'd15) begin
              cnt_r   <= '0;
              state_r <= S_IDLE;
            end else begin
              cnt_r <= cnt_r + 7'd1;
            end
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

endmodule
